// ----- hw/rtl/mlpf_pkg.sv -----
// shared types, codes and the sigmoid table helper for the mlp forward pass
// no dependencies
package mlpf_pkg;

    // item opcodes
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_ACT    = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_LAYER_COUNT  = 3'd0;
    localparam logic [2:0] REG_INPUT_WIDTH  = 3'd1;
    localparam logic [2:0] REG_WIDTH_ONE    = 3'd2;
    localparam logic [2:0] REG_WIDTH_TWO    = 3'd3;
    localparam logic [2:0] REG_WIDTH_THREE  = 3'd4;
    localparam logic [2:0] REG_WIDTH_FOUR   = 3'd5;

    // fixed point layout
    localparam int ACC_W   = 38;          // exact sum of 64 q8.24 products
    localparam int OFF_W   = 28;          // sum offset into [0, 2^28)
    localparam int ACT_W   = 13;          // q1.12 activation, 0..4096
    localparam int VAL_W   = 16;          // q4.12 weight / input
    localparam logic [ACT_W-1:0] ACT_ONE = 13'd4096;

    // configuration register file seen by the controller
    typedef struct packed {
        logic [2:0]      layer_count;
        logic [6:0]      input_width;
        logic [3:0][6:0] width;
    } cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic issue;        // one multiply-accumulate read this cycle
        logic first;        // first term of a dot product
        logic last;         // last term of a dot product
        logic rd_pong;      // source buffer select
        logic wb;           // write the neuron result
        logic dst_pong;     // destination buffer select
        logic final_layer;  // results feed the argmax
        logic first_row;    // first neuron of the layer
        logic out_load;     // load the result registers
        logic out_last;     // final neuron of the run
    } cmd_t;

    // unsigned shift and subtract quotient, elaboration time only
    function automatic longint unsigned mlpf_udiv(input longint unsigned n,
                                                  input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((n >> b) & 64'd1);
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // exp(-16u) in q31 for u in q31, 0 <= u < 1/2, elaboration time only
    function automatic longint unsigned mlpf_exp_neg16(input longint unsigned u);
        longint          sum;
        longint unsigned term;
        longint unsigned e;
        sum  = longint'(64'd1 << 31);
        term = 64'd1 << 31;
        for (int k = 1; k <= 20; k++) begin
            term = mlpf_udiv((term * u) >> 31, 64'(k));
            if ((k & 1) == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        e = longint'(sum);
        for (int k = 0; k < 4; k++) begin
            e = (e * e) >> 31;
        end
        return e;
    endfunction

endpackage

// ----- hw/rtl/mlpf_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
module mlpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/mlpf_datapath.sv -----
// weight store, activation buffers, mac pipeline, sigmoid lookup, argmax, result regs
// depends on mlpf_pkg and mlpf_ram
module mlpf_datapath import mlpf_pkg::*; #(
    parameter int MAX_LAYERS      = 4,
    parameter int MAX_NEURONS     = 64,
    parameter int SIGMOID_ENTRIES = 1024,
    parameter int LW              = 2,
    parameter int IW              = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ld_weight,
    input  logic             ld_act,
    input  logic [1:0]       in_layer,
    input  logic [5:0]       in_row,
    input  logic [5:0]       in_col,
    input  logic [VAL_W-1:0] in_value,
    input  cmd_t             cmd,
    input  logic [LW-1:0]    cmd_layer,
    input  logic [IW-1:0]    cmd_row,
    input  logic [IW-1:0]    cmd_col,
    output logic             acc_done,
    output logic [5:0]       m_neuron_index,
    output logic [ACT_W-1:0] m_activation_out,
    output logic [5:0]       m_best_class,
    output logic             m_run_last
);

    localparam int NW  = $clog2(MAX_NEURONS);
    localparam int WAW = LW + 2 * NW;
    localparam int SW  = $clog2(SIGMOID_ENTRIES);
    localparam int SEW = $clog2(SIGMOID_ENTRIES + 1);
    localparam longint unsigned OneQ31 = 64'd1 << 31;
    localparam longint unsigned EntryN = longint'(SIGMOID_ENTRIES);
    localparam logic signed [ACC_W-1:0] EdgeHi = ACC_W'(64'd1 << 27);
    localparam logic signed [ACC_W-1:0] EdgeLo = -EdgeHi;

    // weight store write and read addresses
    logic           w_ok;
    logic [WAW-1:0] w_waddr;
    logic [WAW-1:0] w_raddr;
    logic [VAL_W-1:0] w_rdata;

    assign w_ok    = ld_weight && (int'(in_layer) < MAX_LAYERS)
                     && (int'(in_row) < MAX_NEURONS) && (int'(in_col) < MAX_NEURONS);
    assign w_waddr = {LW'(in_layer), NW'(in_row), NW'(in_col)};
    assign w_raddr = {cmd_layer, NW'(cmd_row), NW'(cmd_col)};

    mlpf_ram #(.WIDTH(VAL_W), .DEPTH(2 ** WAW)) u_weight (
        .aclk  (aclk),
        .we    (w_ok),
        .waddr (w_waddr),
        .wdata (in_value),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    // activation buffers: inputs land in ping, layers alternate
    logic             act_ok;
    logic             ping_we;
    logic             pong_we;
    logic [NW-1:0]    ping_waddr;
    logic [VAL_W-1:0] ping_wdata;
    logic [NW-1:0]    act_raddr;
    logic [VAL_W-1:0] ping_rdata;
    logic [VAL_W-1:0] pong_rdata;
    logic [VAL_W-1:0] src_rdata;
    logic [ACT_W-1:0] wb_value;

    assign act_ok     = ld_act && (int'(in_col) < MAX_NEURONS);
    assign ping_we    = act_ok || (cmd.wb && !cmd.dst_pong);
    assign pong_we    = cmd.wb && cmd.dst_pong;
    assign ping_waddr = cmd.wb ? NW'(cmd_row) : NW'(in_col);
    assign ping_wdata = cmd.wb ? VAL_W'(wb_value) : in_value;
    assign act_raddr  = cmd.issue ? NW'(cmd_col) : NW'(cmd_row);
    assign src_rdata  = cmd.rd_pong ? pong_rdata : ping_rdata;

    mlpf_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NEURONS)) u_ping (
        .aclk  (aclk),
        .we    (ping_we),
        .waddr (ping_waddr),
        .wdata (ping_wdata),
        .raddr (act_raddr),
        .rdata (ping_rdata)
    );

    mlpf_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NEURONS)) u_pong (
        .aclk  (aclk),
        .we    (pong_we),
        .waddr (NW'(cmd_row)),
        .wdata (VAL_W'(wb_value)),
        .raddr (act_raddr),
        .rdata (pong_rdata)
    );

    // mac pipeline control: read, multiply, accumulate
    logic s1_valid_reg, s1_first_reg, s1_last_reg;
    logic s2_valid_reg, s2_first_reg, s2_last_reg;
    logic done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg && s2_last_reg;
        end
    end

    // mac payload
    logic signed [31:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        prod_reg     <= $signed(w_rdata) * $signed(src_rdata);
        if (s2_valid_reg) begin
            acc_reg <= s2_first_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc_done = done_reg;

    // sigmoid table built at elaboration, bin midpoints over [-8, 8)
    logic [ACT_W-1:0] sig_rom [SIGMOID_ENTRIES];

    for (genvar gi = 0; gi < SIGMOID_ENTRIES; gi++) begin : g_sig
        localparam longint unsigned Twice = 2 * longint'(gi) + 1;
        localparam bit              Pos   = Twice >= EntryN;
        localparam longint unsigned Mag   = Pos ? Twice - EntryN : EntryN - Twice;
        localparam longint unsigned U     = (Mag << 31) / (2 * EntryN);
        localparam longint unsigned E     = mlpf_exp_neg16(U);
        localparam longint unsigned Den   = OneQ31 + E;
        localparam longint unsigned Num   = Pos ? OneQ31 : E;
        localparam longint unsigned Val   = (Num * 4096 + Den / 2) / Den;
        assign sig_rom[gi] = ACT_W'(Val);
    end

    // bin index and saturation from the finished sum
    logic [OFF_W-1:0]     off;
    logic [OFF_W+SEW-1:0] scaled;
    logic [SW-1:0]        idx_reg;
    logic                 sat_lo_reg, sat_hi_reg;
    logic [ACT_W-1:0]     rom_q_reg;

    assign off    = OFF_W'(acc_reg + EdgeHi);
    assign scaled = (OFF_W + SEW)'(off) * (OFF_W + SEW)'(SIGMOID_ENTRIES);

    always_ff @(posedge aclk) begin
        idx_reg    <= SW'(scaled >> OFF_W);
        sat_lo_reg <= acc_reg < EdgeLo;
        sat_hi_reg <= acc_reg >= EdgeHi;
        rom_q_reg  <= sig_rom[idx_reg];
    end

    assign wb_value = sat_lo_reg ? '0 : (sat_hi_reg ? ACT_ONE : rom_q_reg);

    // argmax over the final layer, first maximum wins
    logic [ACT_W-1:0] best_val_reg;
    logic [5:0]       best_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wb && cmd.final_layer && (cmd.first_row || wb_value > best_val_reg)) begin
            best_val_reg <= wb_value;
            best_reg     <= 6'(cmd_row);
        end
    end

    // result registers
    logic [5:0]       m_idx_reg;
    logic [ACT_W-1:0] m_act_reg;
    logic             m_last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_idx_reg  <= 6'(cmd_row);
            m_act_reg  <= src_rdata[ACT_W-1:0];
            m_last_reg <= cmd.out_last;
        end
    end

    assign m_neuron_index   = m_idx_reg;
    assign m_activation_out = m_act_reg;
    assign m_best_class     = best_reg;
    assign m_run_last       = m_last_reg;

endmodule

// ----- hw/rtl/mlpf_ctrl.sv -----
// sequencer for layers, neurons and dot product terms, and for the result phase
// depends on mlpf_pkg
module mlpf_ctrl import mlpf_pkg::*; #(
    parameter int MAX_LAYERS = 4,
    parameter int WIDTH_CAP  = 64,
    parameter int LW         = 2,
    parameter int IW         = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cfg_t          cfg,
    input  logic          start,
    input  logic          acc_done,
    input  logic          m_ready,
    output logic          s_ready,
    output logic          m_valid,
    output cmd_t          cmd,
    output logic [LW-1:0] cmd_layer,
    output logic [IW-1:0] cmd_row,
    output logic [IW-1:0] cmd_col
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MAC   = 8'b0000_0010,
        S_DRAIN = 8'b0000_0100,
        S_SIG   = 8'b0000_1000,
        S_WB    = 8'b0001_0000,
        S_ORD   = 8'b0010_0000,
        S_OWAIT = 8'b0100_0000,
        S_OSEND = 8'b1000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [LW-1:0] layer_reg, layer_next;
    logic [IW-1:0] row_reg, row_next;
    logic [IW-1:0] col_reg, col_next;
    logic [6:0]    prev_reg, prev_next;

    // clamp a count into [1, WIDTH_CAP]
    function automatic logic [6:0] clamp_w(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        if (v == 7'd0) r = 7'd1;
        if (int'(v) > WIDTH_CAP) r = 7'(WIDTH_CAP);
        return r;
    endfunction

    logic [3:0] layers;
    logic [6:0] width;
    logic       col_last, row_last, layer_last;

    always_comb begin
        layers = 4'(cfg.layer_count);
        if (cfg.layer_count == 3'd0) layers = 4'd1;
        if (int'(cfg.layer_count) > MAX_LAYERS) layers = 4'(MAX_LAYERS);
    end

    assign width      = clamp_w(cfg.width[2'(layer_reg)]);
    assign col_last   = 7'(col_reg) + 7'd1 == prev_reg;
    assign row_last   = 7'(row_reg) + 7'd1 == width;
    assign layer_last = 4'(layer_reg) + 4'd1 == layers;

    // next state
    always_comb begin
        state_next = state_reg;
        layer_next = layer_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        prev_next  = prev_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_MAC;
                    layer_next = '0;
                    row_next   = '0;
                    col_next   = '0;
                    prev_next  = clamp_w(cfg.input_width);
                end
            end
            S_MAC: begin
                if (col_last) begin
                    state_next = S_DRAIN;
                    col_next   = '0;
                end else begin
                    col_next = col_reg + IW'(1);
                end
            end
            S_DRAIN: begin
                if (acc_done) state_next = S_SIG;
            end
            S_SIG: state_next = S_WB;
            S_WB: begin
                if (!row_last) begin
                    row_next   = row_reg + IW'(1);
                    state_next = S_MAC;
                end else if (layer_last) begin
                    row_next   = '0;
                    state_next = S_ORD;
                end else begin
                    row_next   = '0;
                    layer_next = layer_reg + LW'(1);
                    prev_next  = width;
                    state_next = S_MAC;
                end
            end
            S_ORD:   state_next = S_OWAIT;
            S_OWAIT: state_next = S_OSEND;
            S_OSEND: begin
                if (m_ready) begin
                    if (row_last) begin
                        state_next = S_IDLE;
                    end else begin
                        row_next   = row_reg + IW'(1);
                        state_next = S_ORD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            layer_reg <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            prev_reg  <= 7'd1;
        end else begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            prev_reg  <= prev_next;
        end
    end

    // commands; the result phase reads the last layer's destination
    logic out_phase;
    assign out_phase = (state_reg == S_ORD) || (state_reg == S_OWAIT)
                       || (state_reg == S_OSEND);

    always_comb begin
        cmd.issue       = state_reg == S_MAC;
        cmd.first       = col_reg == '0;
        cmd.last        = col_last;
        cmd.rd_pong     = out_phase ? !layer_reg[0] : layer_reg[0];
        cmd.wb          = state_reg == S_WB;
        cmd.dst_pong    = !layer_reg[0];
        cmd.final_layer = layer_last;
        cmd.first_row   = row_reg == '0;
        cmd.out_load    = state_reg == S_OWAIT;
        cmd.out_last    = row_last;
    end

    assign cmd_layer = layer_reg;
    assign cmd_row   = row_reg;
    assign cmd_col   = col_reg;
    assign s_ready   = state_reg == S_IDLE;
    assign m_valid   = state_reg == S_OSEND;

endmodule

// ----- hw/rtl/mlp_sigmoid_forward_pass.sv -----
// items: weight and input items are taken only while idle; the item with vector_end starts a
// pass: per neuron, prev terms on one mac unit, one term a cycle, then drain, sigmoid, write back
// results: states ORD, OWAIT, OSEND, held for m_ready; no new item is taken until the last leaves
// reset: synchronous active low aresetn; layer_count 1, all widths 64; stores undefined
// throughput: one vector per pass
// depends on mlpf_pkg, mlpf_ctrl, mlpf_datapath, mlpf_ram
module mlp_sigmoid_forward_pass import mlpf_pkg::*; #(
    parameter int MAX_LAYERS      = 4,
    parameter int MAX_NEURONS     = 64,
    parameter int SIGMOID_ENTRIES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [1:0]  s_layer_sel,
    input  logic [5:0]  s_row_index,
    input  logic [5:0]  s_col_index,
    input  logic [15:0] s_in_value,
    input  logic        s_vector_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_neuron_index,
    output logic [12:0] m_activation_out,
    output logic [5:0]  m_best_class,
    output logic        m_run_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int WidthCap = MAX_NEURONS < 64 ? MAX_NEURONS : 64;
    localparam int LW       = MAX_LAYERS > 1 ? $clog2(MAX_LAYERS) : 1;
    localparam int IW       = $clog2(WidthCap);

    // configuration registers
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.layer_count <= 3'd1;
            cfg_reg.input_width <= 7'd64;
            cfg_reg.width       <= {4{7'd64}};
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LAYER_COUNT: cfg_reg.layer_count <= cfg_data[2:0];
                REG_INPUT_WIDTH: cfg_reg.input_width <= cfg_data;
                REG_WIDTH_ONE:   cfg_reg.width[0]    <= cfg_data;
                REG_WIDTH_TWO:   cfg_reg.width[1]    <= cfg_data;
                REG_WIDTH_THREE: cfg_reg.width[2]    <= cfg_data;
                REG_WIDTH_FOUR:  cfg_reg.width[3]    <= cfg_data;
                default: ;
            endcase
        end
    end

    // input item decode
    logic s_fire, ld_weight, ld_act, start;

    assign s_fire    = s_valid && s_ready;
    assign ld_weight = s_fire && (s_opcode == OP_WEIGHT);
    assign ld_act    = s_fire && (s_opcode == OP_ACT);
    assign start     = ld_act && s_vector_end;

    cmd_t          cmd;
    logic [LW-1:0] cmd_layer;
    logic [IW-1:0] cmd_row;
    logic [IW-1:0] cmd_col;
    logic          acc_done;

    mlpf_ctrl #(
        .MAX_LAYERS (MAX_LAYERS),
        .WIDTH_CAP  (WidthCap),
        .LW         (LW),
        .IW         (IW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .start     (start),
        .acc_done  (acc_done),
        .m_ready   (m_ready),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .cmd       (cmd),
        .cmd_layer (cmd_layer),
        .cmd_row   (cmd_row),
        .cmd_col   (cmd_col)
    );

    mlpf_datapath #(
        .MAX_LAYERS      (MAX_LAYERS),
        .MAX_NEURONS     (MAX_NEURONS),
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES),
        .LW              (LW),
        .IW              (IW)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ld_weight        (ld_weight),
        .ld_act           (ld_act),
        .in_layer         (s_layer_sel),
        .in_row           (s_row_index),
        .in_col           (s_col_index),
        .in_value         (s_in_value),
        .cmd              (cmd),
        .cmd_layer        (cmd_layer),
        .cmd_row          (cmd_row),
        .cmd_col          (cmd_col),
        .acc_done         (acc_done),
        .m_neuron_index   (m_neuron_index),
        .m_activation_out (m_activation_out),
        .m_best_class     (m_best_class),
        .m_run_last       (m_run_last)
    );

    // no input is taken while a result is offered
    assert property (@(posedge aclk) disable iff (!aresetn) m_valid |-> !s_ready)
        else $error("input ready while a result is pending");

    // a starting item leaves the idle state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == OP_ACT && s_vector_end) |=> !s_ready)
        else $error("pass did not start");

    // the final result returns the block to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_run_last) |=> (s_ready && !m_valid))
        else $error("block not idle after the last result");

endmodule

// ----- tb/sv/tb_mlp_sigmoid_forward_pass.sv -----
// self-checking testbench for the mlp sigmoid forward pass block
// depends on mlpf_pkg and mlp_sigmoid_forward_pass; carries its own weight/activation predictor
module tb_mlp_sigmoid_forward_pass;
    import mlpf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NRN       = 64;
    localparam int LAYERS    = 4;
    localparam int ENTRIES   = 1024;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 1500;
    localparam int SETTLE_CYCLES = 30;
    localparam longint EDGE = longint'(8) << 24;

    typedef struct packed {
        logic        op;
        logic [1:0]  lay;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [15:0] val;
        logic        vend;
    } mlp_item_t;

    typedef struct packed {
        logic [5:0]  idx;
        logic [12:0] act;
        logic [5:0]  best;
        logic        rlast;
    } neuron_res_t;

    typedef struct packed {
        mlp_item_t   it;
        logic        chk;
        logic [12:0] a0;
        logic [12:0] a1;
        logic [5:0]  best;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = OP_WEIGHT;
    logic [1:0]  s_layer_sel = '0;
    logic [5:0]  s_row_index = '0;
    logic [5:0]  s_col_index = '0;
    logic [15:0] s_in_value = '0;
    logic        s_vector_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_neuron_index;
    logic [12:0] m_activation_out;
    logic [5:0]  m_best_class;
    logic        m_run_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;

    mlp_sigmoid_forward_pass dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [15:0] sig_lut [ENTRIES];
    logic [15:0] wmem [LAYERS*NRN*NRN];
    bit          wmem_ok [LAYERS*NRN*NRN];
    logic [15:0] act_mem [2][NRN];
    bit          act_ok [2][NRN];
    logic [6:0]  reg_file [6];
    neuron_res_t exp_neurons [$];

    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_passes = 0;
    int burst_left = 0;
    bit hold_req = 0;

    // exp(-16u) in q31, u in q31
    function automatic longint unsigned exp16_q31(input longint unsigned u);
        longint          acc;
        longint unsigned t;
        longint unsigned e;
        acc = longint'(1) << 31;
        t = longint'(1) << 31;
        for (int k = 1; k <= 20; k++) begin
            t = ((t * u) >> 31) / longint'(k);
            if (k % 2 == 1) acc = acc - longint'(t);
            else acc = acc + longint'(t);
        end
        e = longint'(acc);
        repeat (4) e = (e * e) >> 31;
        return e;
    endfunction

    function automatic logic [12:0] sigmoid_of(input longint s);
        longint unsigned k;
        if (s < -EDGE) return 13'd0;
        if (s >= EDGE) return 13'd4096;
        k = (longint'(s + EDGE) * ENTRIES) >> 28;
        if (k >= ENTRIES) k = ENTRIES - 1;
        return sig_lut[k][12:0];
    endfunction

    function automatic int eff_layers();
        int v;
        v = reg_file[REG_LAYER_COUNT];
        return (v < 1) ? 1 : (v > LAYERS) ? LAYERS : v;
    endfunction

    // width of stage s: 0 is the input vector, 1..4 are layers
    function automatic int eff_width(input int s);
        int v;
        v = reg_file[REG_INPUT_WIDTH + s];
        return (v < 1) ? 1 : (v > NRN) ? NRN : v;
    endfunction

    function automatic int waddr(input int l, input int r, input int c);
        return (l * NRN + r) * NRN + c;
    endfunction

    // forward pass over the predictor buffers, queues the final layer neurons
    task automatic forward_pass();
        int          src;
        int          prev;
        int          w;
        int          best;
        longint      acc;
        neuron_res_t res;
        src = 0;
        prev = eff_width(0);
        w = 1;
        for (int l = 0; l < eff_layers(); l++) begin
            w = eff_width(l + 1);
            for (int r = 0; r < w; r++) begin
                acc = 0;
                for (int c = 0; c < prev; c++)
                    acc += longint'($signed(wmem[waddr(l, r, c)]))
                           * longint'($signed(act_mem[src][c]));
                act_mem[1 - src][r] = {3'b000, sigmoid_of(acc)};
                act_ok[1 - src][r] = 1;
            end
            prev = w;
            src = 1 - src;
        end
        best = 0;
        for (int r = 1; r < w; r++)
            if (act_mem[src][r] > act_mem[src][best]) best = r;
        for (int r = 0; r < w; r++) begin
            res.idx = r[5:0];
            res.act = act_mem[src][r][12:0];
            res.best = best[5:0];
            res.rlast = (r + 1 == w);
            exp_neurons.push_back(res);
        end
        n_passes++;
    endtask

    task automatic model_item(input mlp_item_t it);
        if (it.op == OP_WEIGHT) begin
            wmem[waddr(it.lay, it.row, it.col)] = it.val;
            wmem_ok[waddr(it.lay, it.row, it.col)] = 1;
        end else begin
            act_mem[0][it.col] = it.val;
            act_ok[0][it.col] = 1;
            if (it.vend) forward_pass();
        end
    endtask

    // sender: bursts of random length with random gaps; leaves valid high on return
    task automatic send(input mlp_item_t it);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
        end
        s_valid <= 1'b1;
        s_opcode <= it.op;
        s_layer_sel <= it.lay;
        s_row_index <= it.row;
        s_col_index <= it.col;
        s_in_value <= it.val;
        s_vector_end <= it.vend;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        n_items++;
        model_item(it);
    endtask

    // wait for the block to go idle before touching the registers
    task automatic settle();
        s_valid <= 1'b0;
        while (exp_neurons.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_apply(input logic [6:0] v0, v1, v2, v3, v4, v5);
        logic [6:0] vals [6];
        vals = '{v0, v1, v2, v3, v4, v5};
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            reg_file[i] = (i == REG_LAYER_COUNT) ? {4'b0, vals[i][2:0]} : vals[i];
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_val();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 4095)) - 2048);
            2: return 16'($signed($urandom_range(0, 12287)) - 6144);
            3: return 16'($signed($urandom_range(0, 1023)) - 512);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'hffff;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    function automatic mlp_item_t weight_item(input int l, input int r, input int c);
        mlp_item_t it;
        it.op = OP_WEIGHT;
        it.lay = l[1:0];
        it.row = r[5:0];
        it.col = c[5:0];
        it.val = rand_val();
        it.vend = $urandom_range(0, 1);
        return it;
    endfunction

    // make sure every weight the current setting reads has been written
    task automatic load_weights();
        int prev;
        prev = eff_width(0);
        for (int l = 0; l < eff_layers(); l++) begin
            for (int r = 0; r < eff_width(l + 1); r++)
                for (int c = 0; c < prev; c++)
                    if (!wmem_ok[waddr(l, r, c)] || $urandom_range(0, 5) == 0)
                        send(weight_item(l, r, c));
            prev = eff_width(l + 1);
        end
    endtask

    // one input vector: every unwritten position plus a few random ones, shuffled
    task automatic send_vector(input bit pressure);
        int        cols [$];
        int        j;
        int        tmp;
        mlp_item_t it;
        for (int c = 0; c < eff_width(0); c++)
            if (!act_ok[0][c] || $urandom_range(0, 3) == 0) cols.push_back(c);
        repeat ($urandom_range(0, 2)) cols.push_back($urandom_range(0, NRN - 1));
        if (cols.size() == 0) cols.push_back($urandom_range(0, NRN - 1));
        for (int i = cols.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = cols[i];
            cols[i] = cols[j];
            cols[j] = tmp;
        end
        for (int i = 0; i < cols.size(); i++) begin
            // stray weight writes in the middle of a vector
            if ($urandom_range(0, 9) == 0)
                send(weight_item($urandom_range(0, 3), $urandom_range(0, 63),
                                 $urandom_range(0, 63)));
            it.op = OP_ACT;
            it.lay = 2'($urandom);
            it.row = 6'($urandom);
            it.col = cols[i][5:0];
            it.val = rand_val();
            it.vend = (i == cols.size() - 1);
            if (it.vend && pressure) hold_req = 1;
            send(it);
        end
    endtask

    // directed items: saturation both ways, exact range edges, ties, reuse of old inputs
    localparam int DIR_N = 22;
    dir_row_t dir_tab [DIR_N] = '{
        '{'{OP_WEIGHT, 2'd0, 6'd0,  6'd0,  16'h7fff, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_WEIGHT, 2'd0, 6'd0,  6'd1,  16'h7fff, 1'b1}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_WEIGHT, 2'd0, 6'd1,  6'd0,  16'h8000, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_WEIGHT, 2'd0, 6'd1,  6'd1,  16'h8000, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_WEIGHT, 2'd3, 6'd63, 6'd63, 16'h8000, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_WEIGHT, 2'd1, 6'd63, 6'd0,  16'h7fff, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_WEIGHT, 2'd2, 6'd0,  6'd63, 16'h0000, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_ACT,    2'd0, 6'd0,  6'd0,  16'h7fff, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_ACT,    2'd3, 6'd63, 6'd1,  16'h7fff, 1'b1}, 1'b1, 13'd4096, 13'd0, 6'd0},
        '{'{OP_ACT,    2'd0, 6'd0,  6'd0,  16'h8000, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_ACT,    2'd0, 6'd0,  6'd1,  16'h8000, 1'b1}, 1'b1, 13'd0, 13'd4096, 6'd1},
        '{'{OP_ACT,    2'd0, 6'd0,  6'd0,  16'h0000, 1'b1}, 1'b1, 13'd0, 13'd4096, 6'd1},
        '{'{OP_WEIGHT, 2'd0, 6'd0,  6'd0,  16'h2000, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_WEIGHT, 2'd0, 6'd0,  6'd1,  16'h0000, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_WEIGHT, 2'd0, 6'd1,  6'd0,  16'he000, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_WEIGHT, 2'd0, 6'd1,  6'd1,  16'h0000, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_ACT,    2'd0, 6'd0,  6'd0,  16'h4000, 1'b1}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_WEIGHT, 2'd0, 6'd0,  6'd0,  16'h0000, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_WEIGHT, 2'd0, 6'd1,  6'd0,  16'h0000, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_ACT,    2'd0, 6'd0,  6'd1,  16'h0123, 1'b1}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_ACT,    2'd0, 6'd0,  6'd63, 16'hffff, 1'b0}, 1'b0, 13'd0, 13'd0, 6'd0},
        '{'{OP_ACT,    2'd0, 6'd0,  6'd0,  16'h1000, 1'b1}, 1'b0, 13'd0, 13'd0, 6'd0}
    };

    // receiver: long hold on request, otherwise a changing stall pattern
    int hold_left = 0;
    int rx_mode = 0;
    int rx_count = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            rx_count <= rx_count + 1;
            if (rx_count % 48 == 0) rx_mode <= $urandom_range(0, 2);
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge aclk) begin
        neuron_res_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (exp_neurons.size() == 0) begin
                $display("%0t: unexpected result neuron %0d act %0d", $time,
                         m_neuron_index, m_activation_out);
                errors++;
            end else begin
                want = exp_neurons.pop_front();
                if (m_neuron_index !== want.idx) begin
                    $display("%0t: neuron_index expected %0d got %0d", $time,
                             want.idx, m_neuron_index);
                    errors++;
                end
                if (m_activation_out !== want.act) begin
                    $display("%0t: activation_out expected %0d got %0d", $time,
                             want.act, m_activation_out);
                    errors++;
                end
                if (m_best_class !== want.best) begin
                    $display("%0t: best_class expected %0d got %0d", $time,
                             want.best, m_best_class);
                    errors++;
                end
                if (m_run_last !== want.rlast) begin
                    $display("%0t: run_last expected %0d got %0d", $time,
                             want.rlast, m_run_last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("mlp_sigmoid_forward_pass test failed");
            $finish;
        end
    end

    // main sequence
    initial begin
        int twice;
        int mag;
        longint unsigned u;
        longint unsigned e;
        int rand_items;
        // sigmoid lookup for the predictor
        for (int i = 0; i < ENTRIES; i++) begin
            twice = 2 * i + 1;
            mag = (twice >= ENTRIES) ? twice - ENTRIES : ENTRIES - twice;
            u = (longint'(mag) << 31) / (2 * ENTRIES);
            e = exp16_q31(u);
            sig_lut[i] = 16'(((twice >= ENTRIES ? (longint'(1) << 31) : e) * 4096
                              + ((longint'(1) << 31) + e) / 2) / ((longint'(1) << 31) + e));
        end
        reg_file = '{7'd1, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part on a 2 in, 2 out single layer
        cfg_apply(7'd1, 7'd2, 7'd2, 7'd1, 7'd1, 7'd1);
        for (int i = 0; i < DIR_N; i++) begin
            send(dir_tab[i].it);
            if (dir_tab[i].chk) begin
                exp_neurons[$ - 1].act = dir_tab[i].a0;
                exp_neurons[$].act = dir_tab[i].a1;
                exp_neurons[$ - 1].best = dir_tab[i].best;
                exp_neurons[$].best = dir_tab[i].best;
            end
        end

        // widest output: clamped counts, four layers, 64 results, long receiver hold
        settle();
        cfg_apply(7'd7, 7'd1, 7'd1, 7'd1, 7'd1, 7'd127);
        load_weights();
        send_vector(1'b1);
        send_vector(1'b0);
        send_vector(1'b0);

        // zero writes clamp everything to one
        settle();
        cfg_apply(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
        load_weights();
        repeat (2) send_vector(1'b0);

        // random settings with small widths
        rand_items = n_items;
        while (n_items - rand_items < 120) begin
            settle();
            cfg_apply(7'($urandom_range(0, 7)), 7'($urandom_range(0, 6)),
                      7'($urandom_range(0, 6)), 7'($urandom_range(0, 6)),
                      7'($urandom_range(0, 6)), 7'($urandom_range(0, 6)));
            load_weights();
            repeat ($urandom_range(2, 5)) send_vector(1'b0);
        end

        settle();
        $display("covered %0d items and %0d forward passes with %0d results checked",
                 n_items, n_passes, n_results);
        $display("register settings included clamped extremes, ties and saturation");
        if (errors == 0 && exp_neurons.size() == 0) begin
            $display("mlp_sigmoid_forward_pass test passed");
        end else begin
            $display("%0t: %0d mismatches, %0d results never arrived", $time, errors,
                     exp_neurons.size());
            $display("mlp_sigmoid_forward_pass test failed");
        end
        $finish;
    end

endmodule

// ----- mlp_sigmoid_forward_pass.f -----
hw/rtl/mlpf_pkg.sv
hw/rtl/mlpf_ram.sv
hw/rtl/mlpf_datapath.sv
hw/rtl/mlpf_ctrl.sv
hw/rtl/mlp_sigmoid_forward_pass.sv
tb/sv/tb_mlp_sigmoid_forward_pass.sv
